[src/tbep_pkg.sv]
// Shared types, constants and command/status structs of the timed beeper event player.
package tbep_pkg;

	// Event ring geometry.
	localparam int RING_DEPTH = 256;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	// Field widths.
	localparam int TS_W      = 24;
	localparam int TICK_W    = 25;
	localparam int COUNT_W   = 20;
	localparam int PERIOD_W  = 16;
	localparam int POP_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 20;

	// Register reset values.
	localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(70);
	localparam logic [COUNT_W-1:0]  FRAME_END_RESET = COUNT_W'(1997);

	// Saturation limit of the popped counter.
	localparam logic [POP_W-1:0] POP_MAX = '1;

	// Restoring divider: one quotient bit per cycle over the doubled magnitude.
	localparam int DIV_STEPS = TICK_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE       = 2'd0,
		OP_START       = 2'd1,
		OP_START_WRITE = 2'd2,
		OP_TICK        = 2'd3
	} tbep_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_TICK_RD,
		ST_TICK_CMP,
		ST_DONE
	} tbep_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic arm;
		logic div_step;
		logic push;
		logic inc;
		logic pop;
		logic frame_chk;
		logic emit;
	} tbep_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic running;
		logic div_last;
		logic pop_ok;
	} tbep_sts_t;

endpackage

[src/tbep_if.sv]
// Valid/ready channel interfaces for the input and result items.
interface tbep_in_if import tbep_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             op;
	logic signed [TS_W-1:0] timestamp;

	modport source (output valid, output op, output timestamp, input ready);
	modport sink (input valid, input op, input timestamp, output ready);
endinterface

interface tbep_out_if import tbep_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             sound_level;
	logic [POP_W-1:0] toggle_count;
	logic             frame_done;

	modport source (output valid, output sound_level, output toggle_count,
		output frame_done, input ready);
	modport sink (input valid, input sound_level, input toggle_count,
		input frame_done, output ready);
endinterface

[src/tbep_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tbep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/tbep_dp.sv]
// Datapath: configuration, divider, event ring, pointers, tick counter and result register.
module tbep_dp import tbep_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tbep_cmd_t              cmd,
	output tbep_sts_t              sts,
	input  logic signed [TS_W-1:0] timestamp,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic                   sound_level,
	output logic [POP_W-1:0]       toggle_count,
	output logic                   frame_done
);

	logic [PERIOD_W-1:0]  period_q;
	logic [COUNT_W-1:0]   frame_end_q;
	logic [TICK_W-1:0]    acc_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 sign_q;
	logic [RING_AW-1:0]   wp_q;
	logic [RING_AW-1:0]   rp_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 level_q;
	logic                 running_q;
	logic [POP_W-1:0]     popped_q;
	logic                 done_q;

	logic [TS_W-1:0]     mag;
	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W:0]   rem_sh;
	logic                rem_ge;
	logic [PERIOD_W:0]   rem_diff;
	logic [TICK_W-1:0]   ring_wdata;
	logic [TICK_W-1:0]   ring_rdata;
	logic                event_due;

	// Magnitude of the timestamp; the most negative value maps to its own bit pattern.
	assign mag = timestamp[TS_W-1] ? (~timestamp + 1'b1) : timestamp;

	// A zero period divides as a period of one.
	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

	// One restoring division step.
	assign rem_sh   = {rem_q, acc_q[TICK_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, period_eff};
	assign rem_diff = rem_sh - {1'b0, period_eff};

	// Signed tick value written to the ring.
	assign ring_wdata = sign_q ? (~acc_q + 1'b1) : acc_q;

	// Head event is due when its signed tick is at or below the count.
	assign event_due = $signed({ring_rdata[TICK_W-1], ring_rdata})
		<= $signed({{(TICK_W + 1 - COUNT_W){1'b0}}, count_q});

	assign sts.running  = running_q;
	assign sts.div_last = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign sts.pop_ok   = (rp_q != wp_q) && event_due;

	tbep_ram #(
		.WIDTH(TICK_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wp_q),
		.wdata (ring_wdata),
		.raddr (rp_q),
		.rdata (ring_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			frame_end_q <= FRAME_END_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PERIOD:    period_q    <= cfg_data[PERIOD_W-1:0];
				CFG_FRAME_END: frame_end_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Divider and per-item working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q  <= {mag, 1'b0};
			rem_q  <= '0;
			cnt_q  <= '0;
			sign_q <= timestamp[TS_W-1];
		end else if (cmd.div_step) begin
			acc_q <= {acc_q[TICK_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Ring pointers, tick engine and beeper level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			count_q   <= '0;
			level_q   <= 1'b0;
			running_q <= 1'b0;
			popped_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				popped_q <= '0;
				done_q   <= 1'b0;
			end
			if (cmd.arm) begin
				running_q <= 1'b1;
			end
			if (cmd.push) begin
				wp_q <= (wp_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (cmd.inc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop) begin
				rp_q    <= (rp_q == RING_AW'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
				level_q <= ~level_q;
				if (popped_q != POP_MAX) begin
					popped_q <= popped_q + 1'b1;
				end
			end
			if (cmd.frame_chk && (count_q >= frame_end_q)) begin
				count_q   <= count_q - frame_end_q;
				running_q <= 1'b0;
				done_q    <= 1'b1;
			end
		end
	end

	// Result register, loaded when the item is handed to the output side.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sound_level  <= level_q;
			toggle_count <= popped_q;
			frame_done   <= done_q;
		end
	end

endmodule

[src/tbep_ctrl.sv]
// Controller: sequences divide, push and pop loop, and owns both handshakes.
module tbep_ctrl import tbep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  in_op,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  tbep_sts_t   sts,
	output tbep_cmd_t   cmd,
	output tbep_state_t state
);

	tbep_state_t state_q;
	tbep_state_t state_d;
	logic        out_valid_q;
	tbep_op_t    op;

	assign op        = tbep_op_t'(in_op);
	assign state     = state_q;
	assign out_valid = out_valid_q;

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (op)
						OP_WRITE: begin
							state_d = ST_DIV;
						end
						OP_START: begin
							cmd.arm = 1'b1;
							state_d = ST_DONE;
						end
						OP_START_WRITE: begin
							cmd.arm = 1'b1;
							state_d = ST_DIV;
						end
						OP_TICK: begin
							if (sts.running) begin
								cmd.inc = 1'b1;
								state_d = ST_TICK_RD;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_DONE;
			end
			// The registered ring read of the head entry is issued here; its data is compared in ST_TICK_CMP.
			ST_TICK_RD: begin
				state_d = ST_TICK_CMP;
			end
			ST_TICK_CMP: begin
				if (sts.pop_ok) begin
					cmd.pop = 1'b1;
					state_d = ST_TICK_RD;
				end else begin
					cmd.frame_chk = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[src/timed_beeper_event_player.sv]
// Top level of the timed beeper event player: channels, controller and datapath.
//
// Items enter on in_ch (op, timestamp) and each produces exactly one result
// on out_ch (sound_level, toggle_count, frame_done). Configuration is a plain
// write port: cfg_we with cfg_idx 0 for the tick period in half T-states and
// cfg_idx 1 for the frame length in ticks; write only while the block is idle.
// A write event divides 2*|timestamp| by the period in a restoring divider,
// one quotient bit per cycle, and stores the signed tick in a 256-entry ring.
// A tick re-reads the head entry through the registered ring read before
// each pop in the pop loop. One item is worked on at a time; the next is
// accepted as soon as the previous result has been moved into the output
// register, even if the receiver has not yet taken it.
// When the receiver stalls, the result holds on out_ch and the block finishes
// the following item up to its result, then waits. Reset clears pointers,
// tick count, level and engine, and loads the default period and frame
// length; ring contents need no clearing.
module timed_beeper_event_player import tbep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	tbep_in_if.sink              in_ch,
	tbep_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	tbep_cmd_t   cmd;
	tbep_sts_t   sts;
	tbep_state_t state;

	tbep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	tbep_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.timestamp    (in_ch.timestamp),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.sound_level  (out_ch.sound_level),
		.toggle_count (out_ch.toggle_count),
		.frame_done   (out_ch.frame_done)
	);

	// One item in flight: an accepted item blocks the input for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input accepted while an item was still in work");

	// A new result only appears after the controller finished an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state == ST_DONE))
		else $error("result raised outside the completion state");

	// Events are popped only from a non-empty ring with a due head entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> state == ST_TICK_CMP && sts.pop_ok)
		else $error("event popped without a due head entry");

	// The divider hands over to the ring write exactly after its last step.
	assert property (@(posedge clk) disable iff (!arst_n)
		state == ST_DIV && sts.div_last |=> state == ST_PUSH)
		else $error("divider result not pushed after the last step");

endmodule
